FILE: rtl/core/scar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scar_pkg;

	// Largest line table: 8 combs or 4 allpasses per side, two sides
	localparam int unsigned MAX_LINES  = 16;
	localparam int unsigned LEN_BITS   = 16;
	localparam int unsigned PTR_W      = 12;
	localparam int unsigned SPREAD     = 8;
	localparam int unsigned ONE_Q16    = 65536;

	// Configuration register indexes
	localparam logic [7:0] CFG_FEEDBACK = 8'd0;
	localparam logic [7:0] CFG_DAMPING  = 8'd1;

	localparam logic [15:0] FB_RESET   = 16'd58720;
	localparam logic [15:0] DAMP_RESET = 16'd32768;

	typedef logic [MAX_LINES*LEN_BITS-1:0] line_tab_t;

	function automatic int unsigned base_len(input bit is_comb, input int unsigned k);
		int unsigned r;
		r = 1;
		if (is_comb) begin
			case (k)
				0: r = 1116;
				1: r = 1188;
				2: r = 1277;
				3: r = 1356;
				4: r = 1422;
				5: r = 1491;
				6: r = 1557;
				default: r = 1617;
			endcase
		end else begin
			case (k)
				0: r = 556;
				1: r = 441;
				2: r = 341;
				default: r = 225;
			endcase
		end
		return r;
	endfunction

	function automatic int unsigned line_len(input bit is_comb, input int unsigned k,
		input int unsigned side, input int unsigned pct);
		int unsigned n;
		n = ((base_len(is_comb, k) + side * SPREAD) * pct) / 100;
		return (n < 1) ? 1 : n;
	endfunction

	// Lengths of all lines, left side first, 16 bits each
	function automatic line_tab_t line_lens(input bit is_comb, input int unsigned n,
		input int unsigned pct);
		line_tab_t v;
		int unsigned s;
		v = '0;
		for (int unsigned i = 0; i < 2 * n; i++) begin
			s = (i >= n) ? 1 : 0;
			v[LEN_BITS*i +: LEN_BITS] = LEN_BITS'(line_len(is_comb, i - s * n, s, pct));
		end
		return v;
	endfunction

	// Start address of each line in its shared memory
	function automatic line_tab_t line_offs(input bit is_comb, input int unsigned n,
		input int unsigned pct);
		line_tab_t v;
		int unsigned acc;
		int unsigned s;
		v = '0;
		acc = 0;
		for (int unsigned i = 0; i < 2 * n; i++) begin
			s = (i >= n) ? 1 : 0;
			v[LEN_BITS*i +: LEN_BITS] = LEN_BITS'(acc);
			acc = acc + line_len(is_comb, i - s * n, s, pct);
		end
		return v;
	endfunction

	function automatic int unsigned line_total(input bit is_comb, input int unsigned n,
		input int unsigned pct);
		int unsigned acc;
		int unsigned s;
		acc = 0;
		for (int unsigned i = 0; i < 2 * n; i++) begin
			s = (i >= n) ? 1 : 0;
			acc = acc + line_len(is_comb, i - s * n, s, pct);
		end
		return acc;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7fffffff;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/scar_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module scar_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/stereo_comb_allpass_reverb.sv
`timescale 1ns / 1ps
`default_nettype none

// Stereo comb/allpass reverb that adds onto a mix bus. One frame is taken per
// request; for each side in turn it runs through the combs, then the allpasses,
// then the bus mix, on a single shared 32x17 multiplier and one memory per line
// kind (combs, allpasses). Products are formed one at a time on the multiplier:
// each comb needs three products, each side two more for the mix.
// After reset the delay memories are zeroed, one word per cycle, until the
// larger memory (9906 words at default settings) is cleared; no frame is
// taken then, configuration writes are. While a frame is being processed
// configuration writes wait. Registers: 0 comb feedback, 1 comb damping,
// both Q0.16; other indexes are dropped.
module stereo_comb_allpass_reverb
	import scar_pkg::*;
#(
	parameter int unsigned COMBS_PER_SIDE       = 4,
	parameter int unsigned ALLPASSES_PER_SIDE   = 2,
	parameter int unsigned LENGTH_SCALE_PERCENT = 100,
	parameter int unsigned SAMPLE_BITS          = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,

	// tdata: left_in, right_in, bus_left_in, bus_right_in, wet_amount, zero pad
	input  wire logic [((4*SAMPLE_BITS+17+7)/8)*8-1:0] s_axis_tdata,
	input  wire logic                                   s_axis_tvalid,
	output logic                                        s_axis_tready,
	input  wire logic                                   s_axis_tlast,

	// tdata: bus_left_out, bus_right_out, zero pad
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic                               m_axis_tlast,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int unsigned SB      = SAMPLE_BITS;
	localparam int unsigned IN_W    = ((4*SB+17+7)/8)*8;
	localparam int unsigned OUT_W   = ((2*SB+7)/8)*8;
	localparam int unsigned NCL     = 2 * COMBS_PER_SIDE;
	localparam int unsigned NAL     = 2 * ALLPASSES_PER_SIDE;
	localparam int unsigned CL_W    = $clog2(NCL);
	localparam int unsigned AL_W    = $clog2(NAL);
	localparam int unsigned PI_W    = $clog2(NCL + NAL);
	localparam int unsigned C_DEPTH = line_total(1'b1, COMBS_PER_SIDE, LENGTH_SCALE_PERCENT);
	localparam int unsigned A_DEPTH = line_total(1'b0, ALLPASSES_PER_SIDE, LENGTH_SCALE_PERCENT);
	localparam int unsigned CA_W    = $clog2(C_DEPTH);
	localparam int unsigned AA_W    = $clog2(A_DEPTH);
	localparam int unsigned CLR_N   = (C_DEPTH > A_DEPTH) ? C_DEPTH : A_DEPTH;
	localparam int unsigned CLR_W   = $clog2(CLR_N + 1);

	localparam line_tab_t C_LEN = line_lens(1'b1, COMBS_PER_SIDE, LENGTH_SCALE_PERCENT);
	localparam line_tab_t C_OFF = line_offs(1'b1, COMBS_PER_SIDE, LENGTH_SCALE_PERCENT);
	localparam line_tab_t A_LEN = line_lens(1'b0, ALLPASSES_PER_SIDE, LENGTH_SCALE_PERCENT);
	localparam line_tab_t A_OFF = line_offs(1'b0, ALLPASSES_PER_SIDE, LENGTH_SCALE_PERCENT);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_CRD, ST_CM1, ST_CM2, ST_CLP, ST_CM3, ST_CWR,
		ST_ARD, ST_AWR, ST_B1, ST_B2, ST_B3, ST_OUT
	} state_t;

	state_t state_q;

	logic [15:0]             fb_q, damp_q;
	logic [CLR_W-1:0]        clr_q;
	logic                    side_q;
	logic [CL_W-1:0]         cline_q;
	logic [AL_W-1:0]         aline_q;
	logic [PTR_W-1:0]        ptr_q [NCL + NAL];
	logic signed [31:0]      lp_q [NCL];

	logic signed [SB-1:0]    left_q, right_q, busl_q, busr_q;
	logic [16:0]             wet_q;
	logic                    last_q;
	logic signed [31:0]      mono_q, acc_q, o_q, a_q, lpn_q, rev_q, t1_q, mul_q;
	logic signed [SB-1:0]    resl_q, resr_q;
	logic [OUT_W-1:0]        out_data_q;
	logic                    out_valid_q, out_last_q;

	// shared multiplier operands
	logic signed [31:0]      mul_x;
	logic [16:0]             mul_c;
	logic signed [49:0]      prod;
	logic signed [49:0]      prod_r;

	// line addressing
	logic [PI_W-1:0]         pidx;
	logic [PTR_W-1:0]        ptr_cur, ptr_nxt;
	logic [15:0]             len_cur, off_cur, addr_full;
	logic [CA_W-1:0]         c_addr;
	logic [AA_W-1:0]         a_addr;
	logic                    c_we, a_we;
	logic [31:0]             c_wdata, a_wdata, c_rdata, a_rdata;
	logic                    last_comb, last_ap;

	logic signed [31:0]      lp_new, dry_cur, comb_sum, ap_out;
	logic signed [35:0]      bus_sum;
	logic signed [SB-1:0]    bus_sat;
	logic signed [SB:0]      in_sum;

	localparam logic signed [35:0] BUS_HI = (36'sd1 <<< (SB - 1)) - 36'sd1;
	localparam logic signed [35:0] BUS_LO = -(36'sd1 <<< (SB - 1));

	assign cfg_ready     = (state_q == ST_IDLE) || (state_q == ST_CLEAR);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// current line: pointer, length, base address
	always_comb begin
		if (state_q == ST_ARD || state_q == ST_AWR) begin
			pidx    = PI_W'(NCL) + PI_W'(aline_q);
			len_cur = A_LEN[LEN_BITS*aline_q +: LEN_BITS];
			off_cur = A_OFF[LEN_BITS*aline_q +: LEN_BITS];
		end else begin
			pidx    = PI_W'(cline_q);
			len_cur = C_LEN[LEN_BITS*cline_q +: LEN_BITS];
			off_cur = C_OFF[LEN_BITS*cline_q +: LEN_BITS];
		end
		ptr_cur   = ptr_q[pidx];
		ptr_nxt   = ((16'(ptr_cur) + 16'd1) >= len_cur) ? '0 : ptr_cur + PTR_W'(1);
		addr_full = off_cur + 16'(ptr_cur);
		last_comb = side_q ? (cline_q == CL_W'(NCL - 1))
			: (cline_q == CL_W'(COMBS_PER_SIDE - 1));
		last_ap   = side_q ? (aline_q == AL_W'(NAL - 1))
			: (aline_q == AL_W'(ALLPASSES_PER_SIDE - 1));
	end

	// memory ports: clearing pass or line access
	always_comb begin
		if (state_q == ST_CLEAR) begin
			c_addr  = clr_q[CA_W-1:0];
			a_addr  = clr_q[AA_W-1:0];
			c_we    = (32'(clr_q) < C_DEPTH);
			a_we    = (32'(clr_q) < A_DEPTH);
			c_wdata = '0;
			a_wdata = '0;
		end else begin
			c_addr  = addr_full[CA_W-1:0];
			a_addr  = addr_full[AA_W-1:0];
			c_we    = (state_q == ST_CWR);
			a_we    = (state_q == ST_AWR);
			c_wdata = sat32(64'(mono_q) + 64'(mul_q));
			a_wdata = sat32(64'(rev_q) + 64'($signed(a_rdata) >>> 1));
		end
	end

	// datapath helpers
	always_comb begin
		lp_new   = sat32(64'(a_q) + 64'(mul_q));
		comb_sum = sat32(64'(acc_q) + 64'(o_q));
		ap_out   = sat32(64'($signed(a_rdata)) - 64'(rev_q));
		dry_cur  = side_q ? 32'(right_q) : 32'(left_q);
		bus_sum  = 36'(side_q ? busr_q : busl_q) + 36'(t1_q)
			+ 36'(sat32(64'(mul_q) * 64'sd3));
		if (bus_sum > BUS_HI) bus_sat = BUS_HI[SB-1:0];
		else if (bus_sum < BUS_LO) bus_sat = BUS_LO[SB-1:0];
		else bus_sat = bus_sum[SB-1:0];
		in_sum = (SB+1)'($signed(s_axis_tdata[SB-1:0]))
			+ (SB+1)'($signed(s_axis_tdata[2*SB-1:SB]));
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_CM1: begin
				mul_x = $signed(c_rdata);
				mul_c = 17'(ONE_Q16) - 17'(damp_q);
			end
			ST_CM2: begin
				mul_x = lp_q[cline_q];
				mul_c = 17'(damp_q);
			end
			ST_CM3: begin
				mul_x = lpn_q;
				mul_c = 17'(fb_q);
			end
			ST_B1: begin
				mul_x = dry_cur;
				mul_c = 17'(ONE_Q16) - wet_q;
			end
			ST_B2: begin
				mul_x = rev_q;
				mul_c = wet_q;
			end
			default: begin
				mul_x = '0;
				mul_c = '0;
			end
		endcase
		prod   = 50'(mul_x) * $signed({33'd0, mul_c});
		prod_r = (prod + 50'sd32768) >>> 16;
	end

	scar_ram #(.WIDTH(32), .DEPTH(C_DEPTH)) u_comb_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_addr),
		.wdata (c_wdata),
		.raddr (c_addr),
		.rdata (c_rdata)
	);

	scar_ram #(.WIDTH(32), .DEPTH(A_DEPTH)) u_ap_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_addr),
		.wdata (a_wdata),
		.raddr (a_addr),
		.rdata (a_rdata)
	);

	// multiplier output register
	always_ff @(posedge clk) begin
		mul_q <= sat32(64'(prod_r));
	end

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			fb_q        <= FB_RESET;
			damp_q      <= DAMP_RESET;
			clr_q       <= '0;
			side_q      <= 1'b0;
			cline_q     <= '0;
			aline_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NCL + NAL; i++) ptr_q[i] <= '0;
			for (int i = 0; i < NCL; i++) lp_q[i] <= '0;
		end else begin
			// configuration writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_FEEDBACK) fb_q <= cfg_data;
				else if (cfg_index == CFG_DAMPING) damp_q <= cfg_data;
			end
			// result taken; the output state handles its own reload
			if (out_valid_q && m_axis_tready && state_q != ST_OUT) out_valid_q <= 1'b0;

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (32'(clr_q) == CLR_N - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						left_q  <= s_axis_tdata[SB-1:0];
						right_q <= s_axis_tdata[2*SB-1:SB];
						busl_q  <= s_axis_tdata[3*SB-1:2*SB];
						busr_q  <= s_axis_tdata[4*SB-1:3*SB];
						wet_q   <= (s_axis_tdata[4*SB+16:4*SB] > 17'd65536) ? 17'd65536
							: s_axis_tdata[4*SB+16:4*SB];
						last_q  <= s_axis_tlast;
						mono_q  <= 32'(in_sum >>> 1);
						side_q  <= 1'b0;
						cline_q <= '0;
						acc_q   <= '0;
						state_q <= ST_CRD;
					end
				end
				ST_CRD: state_q <= ST_CM1;
				ST_CM1: begin
					o_q     <= $signed(c_rdata);
					state_q <= ST_CM2;
				end
				ST_CM2: begin
					a_q     <= mul_q;
					state_q <= ST_CLP;
				end
				ST_CLP: begin
					lp_q[cline_q] <= lp_new;
					lpn_q         <= lp_new;
					state_q       <= ST_CM3;
				end
				ST_CM3: state_q <= ST_CWR;
				ST_CWR: begin
					ptr_q[pidx] <= ptr_nxt;
					acc_q       <= comb_sum;
					if (last_comb) begin
						rev_q   <= comb_sum;
						aline_q <= side_q ? AL_W'(ALLPASSES_PER_SIDE) : '0;
						state_q <= ST_ARD;
					end else begin
						cline_q <= cline_q + CL_W'(1);
						state_q <= ST_CRD;
					end
				end
				ST_ARD: state_q <= ST_AWR;
				ST_AWR: begin
					ptr_q[pidx] <= ptr_nxt;
					rev_q       <= ap_out;
					if (last_ap) begin
						state_q <= ST_B1;
					end else begin
						aline_q <= aline_q + AL_W'(1);
						state_q <= ST_ARD;
					end
				end
				ST_B1: state_q <= ST_B2;
				ST_B2: begin
					t1_q    <= mul_q;
					state_q <= ST_B3;
				end
				ST_B3: begin
					if (!side_q) begin
						resl_q  <= bus_sat;
						side_q  <= 1'b1;
						cline_q <= CL_W'(COMBS_PER_SIDE);
						acc_q   <= '0;
						state_q <= ST_CRD;
					end else begin
						resr_q  <= bus_sat;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_data_q  <= OUT_W'({resr_q, resl_q});
						out_last_q  <= last_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// no frame is taken during the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_axis_tready)
		else $error("frame accepted while clearing");

	// an accepted frame starts the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_CRD))
		else $error("sequencer did not start");

	// comb write stays inside the comb memory
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CWR) |-> (32'(addr_full) < C_DEPTH))
		else $error("comb address out of range");

	// a result is loaded only on leaving the output state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result loaded outside output state");

endmodule

`default_nettype wire
